// ----- hdl/bls_pkg.sv -----
`timescale 1ns / 1ps

package bls_pkg;

    // Command codes carried on the input channel
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Entries in the request queue between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        OCT_X_RIGHT = 2'd0,
        OCT_Y_RIGHT = 2'd1,
        OCT_Y_LEFT  = 2'd2,
        OCT_X_LEFT  = 2'd3
    } t_octant;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hdl/bls_fifo.sv -----
`timescale 1ns / 1ps

module bls_fifo #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output bls_pkg::t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/bls_front.sv -----
`timescale 1ns / 1ps

module bls_front #(
    parameter int COORD_BITS = 11,
    localparam int ENTRY_W = 7 * COORD_BITS + 11
) (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic [COORD_BITS-1:0]        i_start_x,
    input  logic [COORD_BITS-1:0]        i_start_y,
    input  logic [COORD_BITS-1:0]        i_end_x,
    input  logic [COORD_BITS-1:0]        i_end_y,
    input  logic signed [COORD_BITS:0]   i_delta_x,
    input  logic [COORD_BITS-1:0]        i_delta_y,
    input  logic [1:0]                   i_octant,
    input  bls_pkg::t_q_stat             i_q_stat,
    output logic                         o_push,
    output logic [ENTRY_W-1:0]           o_entry
);

    localparam int TW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 3;

    bls_pkg::t_octant  oct;
    logic              is_load;
    logic              x_major;
    logic              live;
    logic [TW-1:0]     twice_dx;
    logic [TW-1:0]     twice_dy;
    logic [EW-1:0]     err_init;

    assign oct     = bls_pkg::t_octant'(i_octant);
    assign is_load = (i_cmd == bls_pkg::CMD_LOAD);
    assign x_major = (oct == bls_pkg::OCT_X_RIGHT) || (oct == bls_pkg::OCT_X_LEFT);

    // Setup done here so the back end only loads registers
    assign twice_dx = {i_delta_x, 1'b0};
    assign twice_dy = {1'b0, i_delta_y, 1'b0};
    assign err_init = x_major ? {{2{i_delta_x[COORD_BITS]}}, i_delta_x}
                              : {3'b000, i_delta_y};
    // empty line: major axis already at its end
    assign live     = x_major ? (i_start_x != i_end_x) : (i_start_y != i_end_y);

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;
    assign o_entry = {is_load, live, i_octant, i_start_x, i_start_y, i_end_x, i_end_y,
                      twice_dx, twice_dy, err_init};

endmodule

// ----- hdl/bls_back.sv -----
`timescale 1ns / 1ps

module bls_back #(
    parameter int COORD_BITS = 11,
    localparam int ENTRY_W = 7 * COORD_BITS + 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bls_pkg::t_q_stat      i_q_stat,
    input  logic [ENTRY_W-1:0]    i_q_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last
);

    localparam int C  = COORD_BITS;
    localparam int TW = C + 2;
    localparam int EW = C + 3;
    localparam int B0 = EW + 2 * TW;
    localparam logic [C-1:0] ONE = C'(1);

    // queue entry fields
    logic                 q_load;
    logic                 q_live;
    logic [1:0]           q_oct;
    logic [C-1:0]         q_start_x;
    logic [C-1:0]         q_start_y;
    logic [C-1:0]         q_end_x;
    logic [C-1:0]         q_end_y;
    logic [TW-1:0]        q_tdx;
    logic [TW-1:0]        q_tdy;
    logic [EW-1:0]        q_err;

    // line state
    logic [C-1:0]         r_cur_x;
    logic [C-1:0]         r_cur_y;
    logic [C-1:0]         r_stop_x;
    logic [C-1:0]         r_stop_y;
    logic signed [EW-1:0] r_err;
    logic [TW-1:0]        r_tdx;
    logic [TW-1:0]        r_tdy;
    bls_pkg::t_octant     r_mode;
    logic                 r_active;

    // output register
    logic                 r_out_valid;
    logic [C-1:0]         r_px;
    logic [C-1:0]         r_py;
    logic                 r_last;

    logic                 q_valid;
    logic                 out_free;
    logic                 emit;
    logic signed [EW-1:0] tdx_e;
    logic signed [EW-1:0] tdy_e;
    logic signed [EW-1:0] err_a;
    logic signed [EW-1:0] err_b;
    logic                 take;
    logic                 fin;
    logic [C-1:0]         n_cur_x;
    logic [C-1:0]         n_cur_y;
    logic signed [EW-1:0] n_err;

    assign q_err     = i_q_data[EW-1:0];
    assign q_tdy     = i_q_data[EW +: TW];
    assign q_tdx     = i_q_data[EW + TW +: TW];
    assign q_end_y   = i_q_data[B0 +: C];
    assign q_end_x   = i_q_data[B0 + C +: C];
    assign q_start_y = i_q_data[B0 + 2 * C +: C];
    assign q_start_x = i_q_data[B0 + 3 * C +: C];
    assign q_oct     = i_q_data[B0 + 4 * C +: 2];
    assign q_live    = i_q_data[B0 + 4 * C + 2];
    assign q_load    = i_q_data[B0 + 4 * C + 3];

    assign q_valid  = !i_q_stat.empty;
    assign out_free = !r_out_valid || i_ready;
    // loads and idle steps never wait on the output side
    assign o_pop    = q_valid && (q_load || !r_active || out_free);
    assign emit     = o_pop && !q_load && r_active;

    assign tdx_e = {r_tdx[TW-1], r_tdx};
    assign tdy_e = {r_tdy[TW-1], r_tdy};

    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        err_a   = r_err;
        err_b   = r_err;
        take    = 1'b0;
        fin     = 1'b0;
        unique case (r_mode)
            bls_pkg::OCT_X_RIGHT: begin
                n_cur_x = r_cur_x + ONE;
                fin     = (n_cur_x == r_stop_x);
                err_a   = r_err - tdy_e;
                take    = err_a[EW-1];
                err_b   = err_a + tdx_e;
                if (!fin && take) begin
                    n_cur_y = r_cur_y + ONE;
                end
            end
            bls_pkg::OCT_Y_RIGHT: begin
                n_cur_y = r_cur_y + ONE;
                fin     = (n_cur_y == r_stop_y);
                err_a   = r_err - tdx_e;
                take    = err_a[EW-1];
                err_b   = err_a + tdy_e;
                if (!fin && take) begin
                    n_cur_x = r_cur_x + ONE;
                end
            end
            bls_pkg::OCT_Y_LEFT: begin
                n_cur_y = r_cur_y + ONE;
                fin     = (n_cur_y == r_stop_y);
                err_a   = r_err + tdx_e;
                take    = err_a[EW-1] || (err_a == '0);
                err_b   = err_a + tdy_e;
                if (!fin && take) begin
                    n_cur_x = r_cur_x - ONE;
                end
            end
            bls_pkg::OCT_X_LEFT: begin
                n_cur_x = r_cur_x - ONE;
                fin     = (n_cur_x == r_stop_x);
                err_a   = r_err + tdy_e;
                take    = !err_a[EW-1];
                err_b   = err_a + tdx_e;
                if (!fin && take) begin
                    n_cur_y = r_cur_y + ONE;
                end
            end
            default: begin
                n_cur_x = r_cur_x;
            end
        endcase
        if (fin) begin
            n_err = r_err;
        end else if (take) begin
            n_err = err_b;
        end else begin
            n_err = err_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_mode      <= bls_pkg::OCT_X_RIGHT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && q_load) begin
                r_active <= q_live;
                r_mode   <= bls_pkg::t_octant'(q_oct);
            end else if (emit && fin) begin
                r_active <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && q_load) begin
            r_cur_x  <= q_start_x;
            r_cur_y  <= q_start_y;
            r_stop_x <= q_end_x;
            r_stop_y <= q_end_y;
            r_tdx    <= q_tdx;
            r_tdy    <= q_tdy;
            r_err    <= q_err;
        end else if (emit) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
        if (emit) begin
            r_px   <= r_cur_x;
            r_py   <= r_cur_y;
            r_last <= fin;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pixel_x = r_px;
    assign o_pixel_y = r_py;
    assign o_last    = r_last;

endmodule

// ----- hdl/bresenham_line_stepper.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_cmd, i_start_x/y, i_end_x/y, i_delta_x/y, i_octant
// pixel     out        o_valid / i_ready    o_pixel_x, o_pixel_y, o_last
//
// One request per cycle is taken while the queue is not full; a step on an active line gives
// one pixel per cycle unless the output stalls. Requests go into the queue, then the back end's
// error update goes into the output register. A single add-compare-add on the error term sets the cycle.
// Reset (i_rst_n low, synchronous) empties the queue, drops the line and the output.
// A stalled output holds steps in the 2-entry queue; loads and idle steps keep draining.

module bresenham_line_stepper #(
    parameter int COORD_BITS = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic [COORD_BITS-1:0]       i_start_x,
    input  logic [COORD_BITS-1:0]       i_start_y,
    input  logic [COORD_BITS-1:0]       i_end_x,
    input  logic [COORD_BITS-1:0]       i_end_y,
    input  logic signed [COORD_BITS:0]  i_delta_x,
    input  logic [COORD_BITS-1:0]       i_delta_y,
    input  logic [1:0]                  i_octant,
    // pixel channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [COORD_BITS-1:0]       o_pixel_x,
    output logic [COORD_BITS-1:0]       o_pixel_y,
    output logic                        o_last
);

    // queue entry: load flag, live flag, octant, four coordinates,
    // doubled deltas and the initial error term
    localparam int ENTRY_W = 7 * COORD_BITS + 11;

    bls_pkg::t_q_stat    q_stat;
    logic                q_push;
    logic                q_pop;
    logic [ENTRY_W-1:0]  q_wdata;
    logic [ENTRY_W-1:0]  q_rdata;

    // Front: takes requests, precomputes the load setup
    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_delta_x (i_delta_x),
        .i_delta_y (i_delta_y),
        .i_octant  (i_octant),
        .i_q_stat  (q_stat),
        .o_push    (q_push),
        .o_entry   (q_wdata)
    );

    // Queue decouples request intake from pixel stalls
    bls_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (bls_pkg::Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    // Back: line state, error stepping, output register
    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (q_stat),
        .i_q_data  (q_rdata),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_last    (o_last)
    );

`ifndef ASSERT_OFF
    // after reset the queue can take a request and no pixel is pending
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("state not clean after reset");

    // back end must drain the queue whenever the output side can take a pixel
    a_back_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_stat.empty && (!o_valid || i_ready)) |-> q_pop)
        else $error("back end stalled with room at the output");

    // a new pixel only appears after a request left the queue
    a_out_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(q_pop))
        else $error("pixel without a popped request");
`endif

endmodule
